/* sv/arc_polyline_tessellator_unit_assert.svh */
// assertion macros for the arc tessellator
// depends on nothing; included by modules that check their own logic
`ifndef ARC_POLYLINE_TESSELLATOR_UNIT_ASSERT_SVH
`define ARC_POLYLINE_TESSELLATOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked property with reset gating
`define ATP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("atp check failed");
// checked property without reset gating
`define ATP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("atp check failed");
`else
`define ATP_ASSERT(lbl, clk, rstn, prop)
`define ATP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* sv/atp_pkg.sv */
// shared constants, types and the arctangent table for the arc tessellator
// depends on nothing
package atp_pkg;
  localparam int DefMaxSegments = 63;
  localparam int DefCoordBits   = 24;
  localparam int DefAngleBits   = 16;
  localparam int DefCordicIters = 16;

  localparam int SegBits  = 6;
  localparam int VnumBits = 6;
  localparam logic [SegBits-1:0] SegReset = 6'd32;

  // cordic datapath word, turn scaled to 32 fraction bits plus headroom
  localparam int CordicW = 34;
  localparam logic signed [CordicW-1:0] CordicGain = 34'sh026DD3B6A;

  typedef struct packed {
    logic                      valid;
    logic signed [CordicW-1:0] z;
  } cordic_req_t;

  typedef struct packed {
    logic                      valid;
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
  } cordic_rsp_t;

  // atan(2^-i) in 32 fraction bits of a turn
  function automatic logic [31:0] atan_turn(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction
endpackage

/* sv/atp_if.sv */
// handshake channels of the arc tessellator: arc words, vertex words, config
// depends on nothing
interface atp_arc_if #(
  parameter int COORD_BITS = 24,
  parameter int ANGLE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic        [COORD_BITS-2:0] radius_len;
  logic        [ANGLE_BITS-1:0] start_angle;
  logic        [ANGLE_BITS-1:0] end_angle;
  logic                         counter_clockwise;
  modport source (output valid, center_x, center_y, radius_len, start_angle, end_angle,
                  counter_clockwise, input ready);
  modport sink (input valid, center_x, center_y, radius_len, start_angle, end_angle,
                counter_clockwise, output ready);
endinterface

interface atp_vtx_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic [5:0]                   vertex_number;
  logic                         empty_arc;
  logic                         last_vertex;
  modport source (output valid, vertex_x, vertex_y, vertex_number, empty_arc, last_vertex,
                  input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_number, empty_arc, last_vertex,
                output ready);
endinterface

interface atp_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* sv/atp_cordic_cell.sv */
// one cordic rotation cell with fixed shift and arctangent step
// depends on atp_pkg
module atp_cordic_cell import atp_pkg::*; #(
  parameter int          SHIFT = 0,
  parameter logic [31:0] ATAN  = 32'h20000000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cordic_rsp_t prev_i,
  input  logic signed [CordicW-1:0] z_i,
  output cordic_rsp_t next_o,
  output logic signed [CordicW-1:0] z_o
);
  logic valid_q;
  logic signed [CordicW-1:0] x_q, y_q;
  logic signed [CordicW-1:0] z_q;
  logic signed [CordicW-1:0] dx, dy, at;

  assign dx = prev_i.y >>> SHIFT;
  assign dy = prev_i.x >>> SHIFT;
  assign at = $signed({{(CordicW-32){1'b0}}, ATAN});

  // valid is control, data words follow it without reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= prev_i.valid;
    end
  end

  // rotate toward zero residual angle
  always_ff @(posedge clk_i) begin
    if (!z_i[CordicW-1]) begin
      x_q <= prev_i.x - dx;
      y_q <= prev_i.y + dy;
      z_q <= z_i - at;
    end else begin
      x_q <= prev_i.x + dx;
      y_q <= prev_i.y - dy;
      z_q <= z_i + at;
    end
  end

  assign next_o = '{valid: valid_q, x: x_q, y: y_q};
  assign z_o    = z_q;
endmodule

/* sv/atp_sequencer.sv */
// arc sequencer: span divide, vertex angle stepping, placement and result word
// depends on atp_pkg, atp_if.sv and the assertion header
`include "arc_polyline_tessellator_unit_assert.svh"
module atp_sequencer import atp_pkg::*; #(
  parameter int MAX_SEGMENTS = DefMaxSegments,
  parameter int COORD_BITS   = DefCoordBits,
  parameter int ANGLE_BITS   = DefAngleBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  atp_arc_if.sink            arc_i,
  atp_vtx_if.source          vtx_o,
  input  logic [SegBits-1:0] seg_count_i,
  output cordic_req_t        req_o,
  input  cordic_rsp_t        rsp_i
);
  localparam int AW   = ANGLE_BITS;
  localparam int CWD  = COORD_BITS;
  localparam int RW   = COORD_BITS - 1;
  localparam int PW   = RW + 33;
  localparam int QW   = PW - 30;
  localparam int SW   = QW + 2;
  localparam int CNTW = $clog2(AW);
  localparam int MinDiff = (1 << AW) / 6283 + 1;
  localparam logic [PW-1:0] Half = PW'(64'd1 << 29);
  localparam logic signed [SW-1:0] SatHi = SW'((64'sd1 <<< (CWD - 1)) - 1);
  localparam logic signed [SW-1:0] SatLo = SW'(-(64'sd1 <<< (CWD - 1)));

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDiv   = 3'd1;
  localparam logic [2:0] StIssue = 3'd2;
  localparam logic [2:0] StWait  = 3'd3;
  localparam logic [2:0] StMulX  = 3'd4;
  localparam logic [2:0] StMulY  = 3'd5;
  localparam logic [2:0] StFinY  = 3'd6;
  localparam logic [2:0] StOut   = 3'd7;

  logic [2:0] state_q;
  logic signed [CWD-1:0] cx_q, cy_q;
  logic [RW-1:0]  r_q;
  logic [AW-1:0]  st_q, mag_q, dq_q, qacc_q;
  logic           ccw_q, flip_q;
  logic [SegBits-1:0] n_q, drem_q, racc_q;
  logic [CNTW-1:0] dcnt_q;
  logic [VnumBits-1:0] vidx_q;
  logic signed [31:0] cos_q, sin_q;
  logic signed [PW-1:0] prod_q;
  logic out_valid_q, out_empty_q, out_last_q;
  logic signed [CWD-1:0] out_x_q, out_y_q;
  logic [VnumBits-1:0] out_num_q;

  logic signed [AW:0] diff;
  logic [AW:0] absdiff;
  logic [SegBits-1:0] n_eff;
  logic reject, accept, out_take;
  logic [SegBits:0] rem_sh, rsum;
  logic [AW-1:0] angle;
  logic [31:0] z32;
  logic flip;
  logic signed [RW:0] rmul;
  logic signed [CordicW-1:0] cres, sres;

  // round a radius product (30 fraction bits) to coordinate units and add to the center with saturation
  function automatic logic signed [CWD-1:0] place(input logic signed [CWD-1:0] c,
                                                  input logic signed [PW-1:0] p);
    logic [PW-1:0] mag;
    logic [QW-1:0] q;
    logic signed [SW-1:0] s;
    logic signed [CWD-1:0] res;
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    q = QW'((mag + Half) >> 30);
    if (p[PW-1]) begin
      s = SW'(c) - $signed({2'b00, q});
    end else begin
      s = SW'(c) + $signed({2'b00, q});
    end
    if (s > SatHi) begin
      res = SatHi[CWD-1:0];
    end else if (s < SatLo) begin
      res = SatLo[CWD-1:0];
    end else begin
      res = s[CWD-1:0];
    end
    return res;
  endfunction

  // arc screening
  assign diff    = $signed({1'b0, arc_i.end_angle}) - $signed({1'b0, arc_i.start_angle});
  assign absdiff = diff[AW] ? (AW+1)'(-diff) : (AW+1)'(diff);
  assign n_eff   = (32'(seg_count_i) > MAX_SEGMENTS) ? SegBits'(MAX_SEGMENTS) : seg_count_i;
  assign reject  = (32'(absdiff) < MinDiff) || (arc_i.radius_len == '0) || (n_eff < 6'd3);

  assign arc_i.ready = (state_q == StIdle);
  assign accept      = arc_i.valid && arc_i.ready;
  assign out_take    = out_valid_q && vtx_o.ready;

  // divider step and remainder stepping
  assign rem_sh = {drem_q, mag_q[dcnt_q]};
  assign rsum   = {1'b0, racc_q} + {1'b0, drem_q};

  // vertex angle, folded into the right half plane
  assign angle = ccw_q ? (st_q + qacc_q) : (st_q - qacc_q);
  assign z32   = {angle, {(32-AW){1'b0}}};
  assign flip  = z32[31] ^ z32[30];
  assign req_o.valid = (state_q == StIssue);
  assign req_o.z     = $signed({{(CordicW-32){z32[31] ^ flip}}, z32[31] ^ flip, z32[30:0]});

  assign rmul = $signed({1'b0, r_q});
  assign cres = flip_q ? -rsp_i.x : rsp_i.x;
  assign sres = flip_q ? -rsp_i.y : rsp_i.y;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (accept) begin
            if (reject) begin
              out_valid_q <= 1'b1;
              state_q     <= StOut;
            end else begin
              state_q <= StDiv;
            end
          end
        end
        StDiv: begin
          if (dcnt_q == '0) begin
            state_q <= StIssue;
          end
        end
        StIssue: state_q <= StWait;
        StWait: begin
          if (rsp_i.valid) begin
            state_q <= StMulX;
          end
        end
        StMulX: state_q <= StMulY;
        StMulY: state_q <= StFinY;
        StFinY: begin
          out_valid_q <= 1'b1;
          state_q     <= StOut;
        end
        StOut: begin
          if (vtx_o.ready) begin
            out_valid_q <= 1'b0;
            state_q     <= out_last_q ? StIdle : StIssue;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (accept) begin
          cx_q   <= arc_i.center_x;
          cy_q   <= arc_i.center_y;
          r_q    <= arc_i.radius_len;
          st_q   <= arc_i.start_angle;
          ccw_q  <= arc_i.counter_clockwise;
          mag_q  <= arc_i.counter_clockwise ? (arc_i.end_angle - arc_i.start_angle)
                                            : (arc_i.start_angle - arc_i.end_angle);
          n_q    <= n_eff;
          dq_q   <= '0;
          drem_q <= '0;
          dcnt_q <= CNTW'(AW - 1);
          out_x_q     <= '0;
          out_y_q     <= '0;
          out_num_q   <= '0;
          out_empty_q <= 1'b1;
          out_last_q  <= 1'b1;
        end
      end
      StDiv: begin
        if (rem_sh >= {1'b0, n_q}) begin
          drem_q <= SegBits'(rem_sh - {1'b0, n_q});
          dq_q   <= {dq_q[AW-2:0], 1'b1};
        end else begin
          drem_q <= rem_sh[SegBits-1:0];
          dq_q   <= {dq_q[AW-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 1'b1;
        qacc_q <= '0;
        racc_q <= '0;
        vidx_q <= '0;
      end
      StIssue: flip_q <= flip;
      StWait: begin
        cos_q <= cres[31:0];
        sin_q <= sres[31:0];
      end
      StMulX: prod_q <= PW'(rmul) * PW'(cos_q);
      StMulY: begin
        out_x_q <= place(cx_q, prod_q);
        prod_q  <= PW'(rmul) * PW'(sin_q);
      end
      StFinY: begin
        out_y_q     <= place(cy_q, prod_q);
        out_num_q   <= vidx_q;
        out_empty_q <= 1'b0;
        out_last_q  <= (vidx_q == n_q);
      end
      StOut: begin
        if (out_take) begin
          vidx_q <= vidx_q + 1'b1;
          if (rsum >= {1'b0, n_q}) begin
            racc_q <= SegBits'(rsum - {1'b0, n_q});
            qacc_q <= qacc_q + dq_q + 1'b1;
          end else begin
            racc_q <= rsum[SegBits-1:0];
            qacc_q <= qacc_q + dq_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign vtx_o.valid         = out_valid_q;
  assign vtx_o.vertex_x      = out_x_q;
  assign vtx_o.vertex_y      = out_y_q;
  assign vtx_o.vertex_number = out_num_q;
  assign vtx_o.empty_arc     = out_empty_q;
  assign vtx_o.last_vertex   = out_last_q;

  `ATP_ASSERT(a_no_accept_while_out, clk_i, rst_ni, arc_i.ready |-> !vtx_o.valid)
  `ATP_ASSERT(a_empty_is_single, clk_i, rst_ni,
    (vtx_o.valid && vtx_o.empty_arc) |-> (vtx_o.last_vertex && vtx_o.vertex_number == '0))
  `ATP_ASSERT(a_vertex_in_range, clk_i, rst_ni,
    (vtx_o.valid && !vtx_o.empty_arc) |-> (vtx_o.vertex_number <= n_q))
endmodule

/* sv/arc_polyline_tessellator_unit.sv */
// top level of the arc tessellator: config register, cordic cell row, sequencer
// depends on atp_pkg, atp_if.sv, atp_cordic_cell, atp_sequencer
// one arc at a time: the span is first divided by the segment count, then each
// vertex passes the cordic cell row, two multiplies and the output word, plus any
// output stall; an arc of N segments gives N+1 vertices, a rejected arc a single
// empty word
// reset clears control and sets segment_count to 32, block comes up idle
module arc_polyline_tessellator_unit import atp_pkg::*; #(
  parameter int MAX_SEGMENTS      = DefMaxSegments,
  parameter int COORD_BITS        = DefCoordBits,
  parameter int ANGLE_BITS        = DefAngleBits,
  parameter int CORDIC_ITERATIONS = DefCordicIters
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  atp_arc_if.sink   arc_i,
  atp_vtx_if.source vtx_o,
  atp_cfg_if.sink   cfg_i
);
  logic [SegBits-1:0] seg_q;
  cordic_req_t req;
  cordic_rsp_t chain [CORDIC_ITERATIONS+1];
  logic signed [CordicW-1:0] zc [CORDIC_ITERATIONS+1];

  // segment count register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= SegReset;
    end else if (cfg_i.valid) begin
      seg_q <= cfg_i.data;
    end
  end

  // row of cordic cells, gain preloaded into x
  assign chain[0] = '{valid: req.valid, x: CordicGain, y: '0};
  assign zc[0]    = req.z;

  for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cell
    atp_cordic_cell #(
      .SHIFT(g),
      .ATAN (atan_turn(g))
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .prev_i(chain[g]),
      .z_i   (zc[g]),
      .next_o(chain[g+1]),
      .z_o   (zc[g+1])
    );
  end

  atp_sequencer #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .COORD_BITS  (COORD_BITS),
    .ANGLE_BITS  (ANGLE_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .arc_i      (arc_i),
    .vtx_o      (vtx_o),
    .seg_count_i(seg_q),
    .req_o      (req),
    .rsp_i      (chain[CORDIC_ITERATIONS])
  );
endmodule
